// File: design/measurement_dataset_statistics_defines.svh
// assertion macros shared by the measurement statistics block
// no dependencies; the using module must have clk and rst_n in scope
`ifndef MEASUREMENT_DATASET_STATISTICS_DEFINES_SVH
`define MEASUREMENT_DATASET_STATISTICS_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define MDS_ASSERT_HOLD(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// same-cycle implication
`define MDS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MDS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/mds_pkg.sv
// shared types and constants of the measurement statistics block
// no dependencies
package mds_pkg;

  localparam int MAX_READINGS = 1024;
  localparam int IDX_W        = $clog2(MAX_READINGS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int WORD_W       = 32;
  localparam int WIDE_W       = 128;
  localparam int ROOT_W       = WIDE_W / 2;
  localparam int MB_W         = 2 * WORD_W;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_REJECT  = 2'd1,
    OP_RESTORE = 2'd2,
    OP_REPORT  = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // store write and read request
  typedef struct packed {
    logic              data_we;
    logic              flag_we;
    logic [IDX_W-1:0]  waddr;
    logic [WORD_W-1:0] value;
    logic [WORD_W-1:0] unc;
    logic              known;
    logic              flag;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

  // registered read word
  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic [WORD_W-1:0] unc;
    logic              known;
    logic              valid;
  } mem_rd_t;

endpackage

// File: design/measurement_dataset_statistics.sv
// measurement dataset statistics: add, reject, restore, report over up to 1024 readings
// add/reject/restore: result in the cycle after acceptance, a new word every cycle while not busy
// report: busy while it walks every stored entry, with a weight divide and multiply for each kept entry
//   with a known nonzero uncertainty, then the closing divides and square roots
// reset: stored count to zero, store contents undefined; out_valid marks each word once
// depends on mds_pkg, mds_store, mds_div, mds_mul, mds_sqrt and the defines header
`include "measurement_dataset_statistics_defines.svh"

module measurement_dataset_statistics (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic signed [31:0] in_reading_value,
  input  logic [31:0]        in_reading_uncertainty,
  input  logic               in_uncertainty_known,
  input  logic [9:0]         in_item_index,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [10:0]        out_total_count,
  output logic [10:0]        out_kept_count,
  output logic [10:0]        out_known_count,
  output logic signed [31:0] out_mean_value,
  output logic               out_mean_ok,
  output logic [31:0]        out_stddev_value,
  output logic               out_stddev_ok,
  output logic [31:0]        out_standard_error_value,
  output logic signed [31:0] out_weighted_mean_value,
  output logic [31:0]        out_weighted_uncertainty_value,
  output logic               out_weighted_ok
);

  localparam int WW    = mds_pkg::WORD_W;
  localparam int CW    = mds_pkg::CNT_W;
  localparam int IW    = mds_pkg::IDX_W;
  localparam int XW    = mds_pkg::WIDE_W;
  localparam int BW    = mds_pkg::MB_W;
  localparam int RW    = mds_pkg::ROOT_W;
  localparam int SQ_W  = 2 * WW;           // square of a value or uncertainty
  localparam int S_W   = WW + IW + 1;      // signed sum of values
  localparam int Q_W   = 2 * (WW - 1) + IW + 1;  // sum of squared magnitudes
  localparam int WT_W  = SQ_W + 1;         // one weight, up to 2^64
  localparam int W_W   = SQ_W + IW + 1;    // sum of weights
  localparam int P_W   = SQ_W + WW + IW;   // sum of weight times magnitude
  localparam int D_W   = 2 * CW;           // n*(n-1)
  localparam int DN_W  = 3 * CW;           // n*n*(n-1)
  localparam logic [XW-1:0] TWO_POW_64 = XW'(1) << SQ_W;
  localparam logic [WW-1:0] MIN_MAG    = {1'b1, {(WW-1){1'b0}}};
  localparam logic [WW-1:0] MAX_POS    = {1'b0, {(WW-1){1'b1}}};

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_LATCH, S_ACC, S_WDIV, S_PMUL,
    S_MEAN, S_MEANW, S_QN, S_SS, S_VDIV, S_VSQRT, S_EDIV, S_ESQRT,
    S_WSTART, S_WMDIV, S_WUDIV, S_WUSQRT, S_DONE
  } state_t;

  function automatic logic [WW-1:0] sat32(input logic [RW-1:0] v);
    sat32 = (|v[RW-1:WW]) ? '1 : v[WW-1:0];
  endfunction

  // control and accumulators
  state_t                state_r;
  logic [CW-1:0]         cnt_r;
  logic [CW-1:0]         i_r;
  logic [CW-1:0]         n_r;
  logic [CW-1:0]         nq_r;
  logic signed [S_W-1:0] s_r;
  logic [Q_W-1:0]        q_r;
  logic [W_W-1:0]        w_r;
  logic [P_W-1:0]        pos_r;
  logic [P_W-1:0]        neg_r;
  logic                  any_w_r;
  logic                  negw_r;

  // current entry
  logic [WW-1:0]         x_r;
  logic [WW-1:0]         ax_r;
  logic [SQ_W-1:0]       sq_r;
  logic [SQ_W-1:0]       uu_r;
  logic                  vld_r;
  logic                  kn_r;
  logic                  unz_r;
  logic [WT_W-1:0]       wt_r;

  // end-of-report terms
  logic [D_W-1:0]        d_r;
  logic [DN_W-1:0]       dn_r;
  logic [XW-1:0]         a1_r;
  logic [XW-1:0]         var_r;

  // shared arithmetic units
  logic                  div_start_r;
  logic [XW-1:0]         div_num_r;
  logic [XW-1:0]         div_den_r;
  logic                  div_done;
  logic [XW-1:0]         div_quo;
  logic                  mul_start_r;
  logic [XW-1:0]         mul_a_r;
  logic [BW-1:0]         mul_b_r;
  logic                  mul_done;
  logic [XW-1:0]         mul_prod;
  logic                  sq_start_r;
  logic [XW-1:0]         sq_rad_r;
  logic                  sq_done;
  logic [RW-1:0]         sq_root;

  // result word
  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic [CW-1:0]         out_total_r;
  logic [CW-1:0]         out_vcount_r;
  logic [CW-1:0]         out_qcount_r;
  logic [WW-1:0]         out_mean_r;
  logic                  out_mean_ok_r;
  logic [WW-1:0]         out_sd_r;
  logic                  out_sd_ok_r;
  logic [WW-1:0]         out_se_r;
  logic [WW-1:0]         out_wm_r;
  logic [WW-1:0]         out_wu_r;
  logic                  out_w_ok_r;

  // store port
  mds_pkg::mem_req_t     mem_req;
  mds_pkg::mem_rd_t      mem_rd;

  logic                  accept;
  mds_pkg::op_t          op_c;
  logic                  full_c;
  logic                  in_range_c;
  logic [WW-1:0]         ax_c;
  logic [S_W-1:0]        as_c;
  logic                  pn_lt_c;

  assign accept     = start && !busy;
  assign op_c       = mds_pkg::op_t'(in_operation);
  assign full_c     = cnt_r == CW'(mds_pkg::MAX_READINGS);
  assign in_range_c = {1'b0, in_item_index} < cnt_r;
  assign busy       = state_r != S_IDLE;

  // magnitude of the word just read; the most negative value maps to 2^31
  assign ax_c    = mem_rd.value[WW-1] ? WW'(~mem_rd.value + 1'b1) : mem_rd.value;
  assign as_c    = s_r[S_W-1] ? S_W'(-s_r) : S_W'(s_r);
  assign pn_lt_c = pos_r < neg_r;

  // store writes happen at acceptance; reads always follow the walk index
  always_comb begin
    mem_req       = '0;
    mem_req.raddr = i_r[IW-1:0];
    mem_req.value = in_reading_value;
    mem_req.unc   = in_reading_uncertainty;
    mem_req.known = in_uncertainty_known;
    if (accept) begin
      unique case (op_c) inside
        mds_pkg::OP_ADD: begin
          mem_req.data_we = !full_c;
          mem_req.flag_we = !full_c;
          mem_req.waddr   = cnt_r[IW-1:0];
          mem_req.flag    = 1'b1;
        end
        mds_pkg::OP_REJECT, mds_pkg::OP_RESTORE: begin
          mem_req.flag_we = in_range_c;
          mem_req.waddr   = in_item_index;
          mem_req.flag    = op_c == mds_pkg::OP_RESTORE;
        end
        mds_pkg::OP_REPORT: begin
        end
      endcase
    end
  end

  mds_store u_store (
    .clk (clk),
    .req (mem_req),
    .rd  (mem_rd)
  );

  mds_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (div_num_r),
    .den   (div_den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  mds_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start_r),
    .a     (mul_a_r),
    .b     (mul_b_r),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  mds_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start_r),
    .rad   (sq_rad_r),
    .done  (sq_done),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      mul_start_r <= 1'b0;
      sq_start_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      mul_start_r <= 1'b0;
      sq_start_r  <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            // every field but status and count reads zero unless the report fills it
            out_status_r  <= mds_pkg::ST_OK;
            out_total_r   <= cnt_r;
            out_vcount_r  <= '0;
            out_qcount_r  <= '0;
            out_mean_r    <= '0;
            out_mean_ok_r <= 1'b0;
            out_sd_r      <= '0;
            out_sd_ok_r   <= 1'b0;
            out_se_r      <= '0;
            out_wm_r      <= '0;
            out_wu_r      <= '0;
            out_w_ok_r    <= 1'b0;
            unique case (op_c) inside
              mds_pkg::OP_ADD: begin
                if (full_c) begin
                  out_status_r <= mds_pkg::ST_FULL;
                end else begin
                  cnt_r       <= cnt_r + 1'b1;
                  out_total_r <= cnt_r + 1'b1;
                end
                out_valid_r <= 1'b1;
              end
              mds_pkg::OP_REJECT, mds_pkg::OP_RESTORE: begin
                if (!in_range_c) begin
                  out_status_r <= mds_pkg::ST_RANGE;
                end
                out_valid_r <= 1'b1;
              end
              mds_pkg::OP_REPORT: begin
                i_r     <= '0;
                n_r     <= '0;
                nq_r    <= '0;
                s_r     <= '0;
                q_r     <= '0;
                w_r     <= '0;
                pos_r   <= '0;
                neg_r   <= '0;
                any_w_r <= 1'b0;
                state_r <= S_RD;
              end
            endcase
          end
        end

        // walk: address out, then registered word, then accumulate
        S_RD: begin
          state_r <= (i_r == cnt_r) ? S_MEAN : S_LATCH;
        end

        S_LATCH: begin
          x_r     <= mem_rd.value;
          ax_r    <= ax_c;
          sq_r    <= SQ_W'(ax_c) * SQ_W'(ax_c);
          uu_r    <= SQ_W'(mem_rd.unc) * SQ_W'(mem_rd.unc);
          vld_r   <= mem_rd.valid;
          kn_r    <= mem_rd.known;
          unz_r   <= mem_rd.unc != '0;
          i_r     <= i_r + 1'b1;
          state_r <= S_ACC;
        end

        S_ACC: begin
          state_r <= S_RD;
          if (vld_r) begin
            n_r <= n_r + 1'b1;
            s_r <= s_r + S_W'(signed'(x_r));
            q_r <= q_r + Q_W'(sq_r);
            if (kn_r) begin
              nq_r <= nq_r + 1'b1;
              // zero uncertainty counts as quantified but carries no weight
              if (unz_r) begin
                div_start_r <= 1'b1;
                div_num_r   <= TWO_POW_64;
                div_den_r   <= XW'(uu_r);
                state_r     <= S_WDIV;
              end
            end
          end
        end

        S_WDIV: begin
          if (div_done) begin
            wt_r        <= div_quo[WT_W-1:0];
            mul_start_r <= 1'b1;
            mul_a_r     <= XW'(div_quo[WT_W-1:0]);
            mul_b_r     <= BW'(ax_r);
            state_r     <= S_PMUL;
          end
        end

        S_PMUL: begin
          if (mul_done) begin
            w_r <= w_r + W_W'(wt_r);
            if (x_r[WW-1]) begin
              neg_r <= neg_r + mul_prod[P_W-1:0];
            end else begin
              pos_r <= pos_r + mul_prod[P_W-1:0];
            end
            any_w_r <= 1'b1;
            state_r <= S_RD;
          end
        end

        // plain mean, truncated toward zero
        S_MEAN: begin
          out_vcount_r <= n_r;
          out_qcount_r <= nq_r;
          if (n_r == '0) begin
            state_r <= S_WSTART;
          end else begin
            div_start_r <= 1'b1;
            div_num_r   <= XW'(as_c);
            div_den_r   <= XW'(n_r);
            state_r     <= S_MEANW;
          end
        end

        S_MEANW: begin
          if (div_done) begin
            out_mean_r    <= s_r[S_W-1] ? WW'(-div_quo[WW-1:0]) : div_quo[WW-1:0];
            out_mean_ok_r <= 1'b1;
            if (n_r >= CW'(2)) begin
              d_r         <= D_W'(n_r) * D_W'(n_r - 1'b1);
              mul_start_r <= 1'b1;
              mul_a_r     <= XW'(q_r);
              mul_b_r     <= BW'(n_r);
              state_r     <= S_QN;
            end else begin
              state_r <= S_WSTART;
            end
          end
        end

        // spread term n*Q - S*S
        S_QN: begin
          if (mul_done) begin
            a1_r        <= mul_prod;
            dn_r        <= DN_W'(d_r) * DN_W'(n_r);
            mul_start_r <= 1'b1;
            mul_a_r     <= XW'(as_c);
            mul_b_r     <= BW'(as_c);
            state_r     <= S_SS;
          end
        end

        S_SS: begin
          if (mul_done) begin
            var_r       <= a1_r - mul_prod;
            div_start_r <= 1'b1;
            div_num_r   <= a1_r - mul_prod;
            div_den_r   <= XW'(d_r);
            state_r     <= S_VDIV;
          end
        end

        S_VDIV: begin
          if (div_done) begin
            sq_start_r <= 1'b1;
            sq_rad_r   <= div_quo;
            state_r    <= S_VSQRT;
          end
        end

        S_VSQRT: begin
          if (sq_done) begin
            out_sd_r    <= sat32(sq_root);
            out_sd_ok_r <= 1'b1;
            div_start_r <= 1'b1;
            div_num_r   <= var_r;
            div_den_r   <= XW'(dn_r);
            state_r     <= S_EDIV;
          end
        end

        S_EDIV: begin
          if (div_done) begin
            sq_start_r <= 1'b1;
            sq_rad_r   <= div_quo;
            state_r    <= S_ESQRT;
          end
        end

        S_ESQRT: begin
          if (sq_done) begin
            out_se_r <= sat32(sq_root);
            state_r  <= S_WSTART;
          end
        end

        // weighted mean from signed-split partial sums
        S_WSTART: begin
          if (!any_w_r) begin
            state_r <= S_DONE;
          end else begin
            negw_r      <= pn_lt_c;
            div_start_r <= 1'b1;
            div_num_r   <= pn_lt_c ? XW'(neg_r - pos_r) : XW'(pos_r - neg_r);
            div_den_r   <= XW'(w_r);
            state_r     <= S_WMDIV;
          end
        end

        S_WMDIV: begin
          if (div_done) begin
            if (negw_r) begin
              out_wm_r <= (|div_quo[XW-1:WW] || div_quo[WW-1:0] > MIN_MAG) ?
                          MIN_MAG : WW'(-div_quo[WW-1:0]);
            end else begin
              out_wm_r <= (|div_quo[XW-1:WW] || div_quo[WW-1:0] > MAX_POS) ?
                          MAX_POS : div_quo[WW-1:0];
            end
            div_start_r <= 1'b1;
            div_num_r   <= TWO_POW_64;
            div_den_r   <= XW'(w_r);
            state_r     <= S_WUDIV;
          end
        end

        S_WUDIV: begin
          if (div_done) begin
            sq_start_r <= 1'b1;
            sq_rad_r   <= div_quo;
            state_r    <= S_WUSQRT;
          end
        end

        S_WUSQRT: begin
          if (sq_done) begin
            out_wu_r   <= sat32(sq_root);
            out_w_ok_r <= 1'b1;
            state_r    <= S_DONE;
          end
        end

        S_DONE: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid                      = out_valid_r;
  assign out_status                     = out_status_r;
  assign out_total_count                = out_total_r;
  assign out_kept_count                 = out_vcount_r;
  assign out_known_count                = out_qcount_r;
  assign out_mean_value                 = out_mean_r;
  assign out_mean_ok                    = out_mean_ok_r;
  assign out_stddev_value               = out_sd_r;
  assign out_stddev_ok                  = out_sd_ok_r;
  assign out_standard_error_value       = out_se_r;
  assign out_weighted_mean_value        = out_wm_r;
  assign out_weighted_uncertainty_value = out_wu_r;
  assign out_weighted_ok                = out_w_ok_r;

  logic counts_nested_c;
  logic sd_gate_c;
  logic report_acc_c;

  assign counts_nested_c = (out_vcount_r <= out_total_r) && (out_qcount_r <= out_vcount_r);
  assign sd_gate_c       = out_mean_ok_r && (out_vcount_r > CW'(1));
  assign report_acc_c    = accept && (op_c == mds_pkg::OP_REPORT);

  // counts in a result word nest inside each other
  `MDS_ASSERT_IMP(a_counts_nested, out_valid, counts_nested_c, "result counts out of order")
  // a deviation needs a mean and two readings
  `MDS_ASSERT_IMP(a_stddev_gated, out_valid && out_stddev_ok, sd_gate_c, "stddev too early")
  // a weighted result needs a quantified reading
  `MDS_ASSERT_IMP(a_weighted_gated, out_valid && out_weighted_ok, out_qcount_r != '0, "no weight")
  // a report holds off further words
  `MDS_ASSERT_NXT(a_report_busy, report_acc_c, busy, "report did not raise busy")
  // the fill count never passes the depth
  `MDS_ASSERT_HOLD(a_count_bound, cnt_r <= CW'(mds_pkg::MAX_READINGS), "stored count beyond depth")

endmodule

// File: design/mds_store.sv
// reading store: data memory and valid-flag memory, registered read
// depends on mds_pkg
module mds_store (
  input  logic              clk,
  input  mds_pkg::mem_req_t req,
  output mds_pkg::mem_rd_t  rd
);

  localparam int DW = 2 * mds_pkg::WORD_W + 1;

  logic [DW-1:0] data_mem [mds_pkg::MAX_READINGS];
  logic          flag_mem [mds_pkg::MAX_READINGS];
  logic [DW-1:0] data_r;
  logic          flag_r;

  always_ff @(posedge clk) begin
    if (req.data_we) begin
      data_mem[req.waddr] <= {req.known, req.unc, req.value};
    end
    if (req.flag_we) begin
      flag_mem[req.waddr] <= req.flag;
    end
    data_r <= data_mem[req.raddr];
    flag_r <= flag_mem[req.raddr];
  end

  assign rd.known = data_r[DW-1];
  assign rd.unc   = data_r[DW-2 -: mds_pkg::WORD_W];
  assign rd.value = data_r[mds_pkg::WORD_W-1:0];
  assign rd.valid = flag_r;

endmodule

// File: design/mds_div.sv
// restoring divider, one quotient bit per cycle
// depends on mds_pkg
module mds_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [mds_pkg::WIDE_W-1:0] num,
  input  logic [mds_pkg::WIDE_W-1:0] den,
  output logic                       done,
  output logic [mds_pkg::WIDE_W-1:0] quo
);

  localparam int W  = mds_pkg::WIDE_W;
  localparam int CW = $clog2(W);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  num_r;
  logic [W-1:0]  den_r;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  quo_r;
  logic [W:0]    rem_sh;
  logic          ge;

  assign rem_sh = {rem_r, num_r[W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
        quo_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? W'(rem_sh - {1'b0, den_r}) : rem_sh[W-1:0];
        quo_r <= {quo_r[W-2:0], ge};
        num_r <= {num_r[W-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// File: design/mds_mul.sv
// shift-add multiplier, one multiplier bit per cycle, stops when bits run out
// depends on mds_pkg
module mds_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [mds_pkg::WIDE_W-1:0] a,
  input  logic [mds_pkg::MB_W-1:0]   b,
  output logic                       done,
  output logic [mds_pkg::WIDE_W-1:0] prod
);

  localparam int W  = mds_pkg::WIDE_W;
  localparam int BW = mds_pkg::MB_W;

  logic          busy_r;
  logic          done_r;
  logic [W-1:0]  a_r;
  logic [BW-1:0] b_r;
  logic [W-1:0]  acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= a;
        b_r    <= b;
        acc_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (b_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          if (b_r[0]) begin
            acc_r <= acc_r + a_r;
          end
          a_r <= {a_r[W-2:0], 1'b0};
          b_r <= {1'b0, b_r[BW-1:1]};
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// File: design/mds_sqrt.sv
// integer square root, two radicand bits per cycle, floor result
// depends on mds_pkg
module mds_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [mds_pkg::WIDE_W-1:0] rad,
  output logic                       done,
  output logic [mds_pkg::ROOT_W-1:0] root
);

  localparam int W  = mds_pkg::WIDE_W;
  localparam int RW = mds_pkg::ROOT_W;
  localparam int MW = RW + 3;
  localparam int CW = $clog2(RW);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  rad_r;
  logic [RW-1:0] root_r;
  logic [MW-1:0] rem_r;
  logic [MW-1:0] rem_sh;
  logic [MW-1:0] trial;
  logic          ge;

  assign rem_sh = {rem_r[MW-3:0], rad_r[W-1 -: 2]};
  assign trial  = MW'({root_r, 2'b01});
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rad_r  <= rad;
        root_r <= '0;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r  <= ge ? rem_sh - trial : rem_sh;
        root_r <= {root_r[RW-2:0], ge};
        rad_r  <= {rad_r[W-3:0], 2'b00};
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == CW'(RW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
